// ===== sv/csb_pkg.sv =====
// Package for the comment and docstring blanker: lexer mode codes, character
// constants and the lexer state record shared by the lexer and the top level.
// No dependencies.
package csb_pkg;

	// Lexer modes; code 7 is unused and is handled as code mode
	typedef enum logic [2:0] {
		MODE_CODE  = 3'd0,
		MODE_SQ    = 3'd1,
		MODE_DQ    = 3'd2,
		MODE_TSQ   = 3'd3,
		MODE_TDQ   = 3'd4,
		MODE_LINE  = 3'd5,
		MODE_BLOCK = 3'd6
	} lex_mode_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// Lexer state carried from byte to byte
	typedef struct packed {
		lex_mode_t  mode;
		logic       esc;
		logic [1:0] skip;
	} lex_state_t;

	localparam lex_state_t LEX_RESET = '{mode: MODE_CODE, esc: 1'b0, skip: 2'd0};

endpackage

// ===== sv/csb_lex.sv =====
// Lexer step for the comment and docstring blanker: decides the output byte
// for one source byte from the lexer state and two bytes of lookahead.
// Depends on csb_pkg.
module csb_lex import csb_pkg::*; (
	input  logic [7:0] c,
	input  logic [7:0] n1,
	input  logic [7:0] n2,
	input  lex_state_t cur,
	output lex_state_t nxt,
	output logic [7:0] out_byte
);

	logic [7:0] quote;
	logic       sq_triple;
	logic       dq_triple;
	logic       q_triple;
	logic       block_end;
	logic [7:0] nl_kept;

	// Shared window decodes
	always_comb begin
		quote     = (cur.mode == MODE_TSQ) ? CH_SQ : CH_DQ;
		sq_triple = (c == CH_SQ) && (n1 == CH_SQ) && (n2 == CH_SQ);
		dq_triple = (c == CH_DQ) && (n1 == CH_DQ) && (n2 == CH_DQ);
		q_triple  = (c == quote) && (n1 == quote) && (n2 == quote);
		block_end = (c == CH_STAR) && (n1 == CH_SLASH);
		nl_kept   = (c == CH_NL) ? c : CH_SP;
	end

	// Next lexer state
	always_comb begin
		nxt = cur;
		if (cur.skip != 2'd0) begin
			nxt.skip = cur.skip - 2'd1;
		end else begin
			case (cur.mode)
				MODE_LINE: begin
					if (c == CH_NL) nxt.mode = MODE_CODE;
				end
				MODE_BLOCK: begin
					if (block_end) begin
						nxt.skip = 2'd1;
						nxt.mode = MODE_CODE;
					end
				end
				MODE_TSQ, MODE_TDQ: begin
					if (q_triple) begin
						nxt.skip = 2'd2;
						nxt.mode = MODE_CODE;
					end
				end
				MODE_SQ, MODE_DQ: begin
					if (cur.esc) begin
						nxt.esc = 1'b0;
					end else if (c == CH_BSL) begin
						nxt.esc = 1'b1;
					end else if ((cur.mode == MODE_SQ && c == CH_SQ) ||
					             (cur.mode == MODE_DQ && c == CH_DQ)) begin
						nxt.mode = MODE_CODE;
					end
				end
				default: begin
					nxt.mode = MODE_CODE;
					if (sq_triple) begin
						nxt.skip = 2'd2;
						nxt.mode = MODE_TSQ;
					end else if (dq_triple) begin
						nxt.skip = 2'd2;
						nxt.mode = MODE_TDQ;
					end else if (c == CH_SQ) begin
						nxt.mode = MODE_SQ;
					end else if (c == CH_DQ) begin
						nxt.mode = MODE_DQ;
					end else if (c == CH_SLASH && n1 == CH_SLASH) begin
						nxt.skip = 2'd1;
						nxt.mode = MODE_LINE;
					end else if (c == CH_SLASH && n1 == CH_STAR) begin
						nxt.skip = 2'd1;
						nxt.mode = MODE_BLOCK;
					end else if (c == CH_HASH) begin
						nxt.mode = MODE_LINE;
					end
				end
			endcase
		end
	end

	// Output byte
	always_comb begin
		out_byte = c;
		if (cur.skip != 2'd0) begin
			out_byte = CH_SP;
		end else begin
			case (cur.mode)
				MODE_LINE:          out_byte = (c == CH_NL) ? c : CH_SP;
				MODE_BLOCK:         out_byte = block_end ? CH_SP : nl_kept;
				MODE_TSQ, MODE_TDQ: out_byte = q_triple ? CH_SP : nl_kept;
				MODE_SQ, MODE_DQ:   out_byte = c;
				default: begin
					if (sq_triple || dq_triple || c == CH_HASH ||
					    (c == CH_SLASH && (n1 == CH_SLASH || n1 == CH_STAR)))
						out_byte = CH_SP;
					else
						out_byte = c;
				end
			endcase
		end
	end

endmodule

// ===== sv/comment_and_docstring_blanker.sv =====
// Channel   Dir  tdata[7:0]  tlast     Notes
// s_axis    in   in_byte     in_last   source text, one byte per transaction
// m_axis    out  out_byte    out_last  same text, comments and triples blanked
//
// Cycles: one byte in and one byte out per cycle in steady state; output trails
// input by two bytes held for lookahead. The first two bytes of a text give no
// output. A transaction with tlast flushes up to three bytes: the input stays
// stalled while the lexer step emits the ones still held in the window.
// Reset clears the lexer state, the window fill and the output valid flag.
// Output stalls hold the result register and back-pressure the input.
// Top level; depends on csb_pkg and csb_lex.
module comment_and_docstring_blanker import csb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast
);

	logic [7:0] w0_q, w1_q;
	logic [1:0] fill_q;
	logic       drain_q;
	logic [1:0] drain_cnt_q;
	lex_state_t lex_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       out_free, s_acc, fire, fire_last, finish;
	logic [7:0] c, n1, n2, lex_byte;
	lex_state_t lex_next;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !drain_q && out_free;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	// Select the three-byte window for the lexer step
	always_comb begin
		if (drain_q) begin
			c = w0_q; n1 = w1_q; n2 = CH_NUL;
		end else begin
			case (fill_q)
				2'd2:    begin c = w0_q;         n1 = w1_q;         n2 = s_axis_tdata; end
				2'd1:    begin c = w0_q;         n1 = s_axis_tdata; n2 = CH_NUL;       end
				default: begin c = s_axis_tdata; n1 = CH_NUL;       n2 = CH_NUL;       end
			endcase
		end
	end

	assign fire      = drain_q ? out_free : (s_acc && (s_axis_tlast || fill_q == 2'd2));
	assign fire_last = drain_q ? (drain_cnt_q == 2'd1) : (s_axis_tlast && fill_q == 2'd0);
	assign finish    = fire && fire_last;

	csb_lex u_lex (
		.c        (c),
		.n1       (n1),
		.n2       (n2),
		.cur      (lex_q),
		.nxt      (lex_next),
		.out_byte (lex_byte)
	);

	// Window, fill and flush control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= 2'd0;
			drain_q     <= 1'b0;
			drain_cnt_q <= 2'd0;
			lex_q       <= LEX_RESET;
		end else if (finish) begin
			fill_q      <= 2'd0;
			drain_q     <= 1'b0;
			drain_cnt_q <= 2'd0;
			lex_q       <= LEX_RESET;
		end else if (fire) begin
			lex_q <= lex_next;
			if (drain_q) begin
				drain_cnt_q <= drain_cnt_q - 2'd1;
			end else if (s_axis_tlast) begin
				drain_q     <= 1'b1;
				drain_cnt_q <= fill_q;
			end
		end else if (s_acc) begin
			fill_q <= fill_q + 2'd1;
		end
	end

	// Window payload: shift on a lexer step, append while filling
	always_ff @(posedge clk) begin
		if (fire) begin
			w0_q <= n1;
			w1_q <= n2;
		end else if (s_acc) begin
			if (fill_q == 2'd0) w0_q <= s_axis_tdata;
			else                w1_q <= s_axis_tdata;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= lex_byte;
			out_last_q <= fire_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;

	// Checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("window fill out of range");

	a_drain_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (drain_cnt_q == 2'd1 || drain_cnt_q == 2'd2))
		else $error("flush count invalid while draining");

	a_drain_full: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> fill_q == 2'd2 || fill_q == 2'd1)
		else $error("flush entered with empty window");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_axis_tlast && fill_q == 2'd0) |=>
		(m_axis_tvalid && m_axis_tlast && !drain_q && fill_q == 2'd0))
		else $error("single-byte flush did not end the text");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (lex_q == LEX_RESET && fill_q == 2'd0 && !drain_q))
		else $error("state not cleared after final byte");

endmodule

// ===== dv/comment_and_docstring_blanker_tb.sv =====
// Testbench for comment_and_docstring_blanker: streams directed and random source texts
// through the block and checks every output byte against a lexer kept in the bench.
// Depends on csb_pkg and the comment_and_docstring_blanker RTL.
module comment_and_docstring_blanker_tb;
	import csb_pkg::*;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} text_beat_t;

	// Mirror of the lexer: tracks the text as it is accepted and queues the blanked bytes
	class blanked_text_board;
		lex_mode_t  mode;
		logic       esc;
		logic [1:0] skip;
		logic [7:0] window [2];
		int         fill;
		text_beat_t blanked_due [$];
		int         faults;

		function new();
			faults = 0;
			clear_lexer();
		endfunction

		function void clear_lexer();
			mode = MODE_CODE;
			esc = 1'b0;
			skip = 2'd0;
			window[0] = CH_NUL;
			window[1] = CH_NUL;
			fill = 0;
		endfunction

		function int outstanding();
			return blanked_due.size();
		endfunction

		// Decide one output byte from the byte and its two successors
		function logic [7:0] blank_byte(logic [7:0] c, logic [7:0] n1, logic [7:0] n2);
			logic [7:0] q;
			if (skip != 2'd0) begin
				skip = skip - 2'd1;
				return CH_SP;
			end
			case (mode)
				MODE_LINE: begin
					if (c == CH_NL) begin
						mode = MODE_CODE;
						return c;
					end
					return CH_SP;
				end
				MODE_BLOCK: begin
					if (c == CH_STAR && n1 == CH_SLASH) begin
						skip = 2'd1;
						mode = MODE_CODE;
						return CH_SP;
					end
					return (c == CH_NL) ? c : CH_SP;
				end
				MODE_TSQ, MODE_TDQ: begin
					q = (mode == MODE_TSQ) ? CH_SQ : CH_DQ;
					if (c == q && n1 == q && n2 == q) begin
						skip = 2'd2;
						mode = MODE_CODE;
						return CH_SP;
					end
					return (c == CH_NL) ? c : CH_SP;
				end
				MODE_SQ, MODE_DQ: begin
					if (esc) begin
						esc = 1'b0;
						return c;
					end
					if (c == CH_BSL) begin
						esc = 1'b1;
						return c;
					end
					if ((mode == MODE_SQ && c == CH_SQ) || (mode == MODE_DQ && c == CH_DQ))
						mode = MODE_CODE;
					return c;
				end
				default: ;
			endcase
			// Code mode: look for an opening delimiter
			mode = MODE_CODE;
			if (c == CH_SQ && n1 == CH_SQ && n2 == CH_SQ) begin
				skip = 2'd2;
				mode = MODE_TSQ;
				return CH_SP;
			end
			if (c == CH_DQ && n1 == CH_DQ && n2 == CH_DQ) begin
				skip = 2'd2;
				mode = MODE_TDQ;
				return CH_SP;
			end
			if (c == CH_SQ) begin
				mode = MODE_SQ;
				return c;
			end
			if (c == CH_DQ) begin
				mode = MODE_DQ;
				return c;
			end
			if (c == CH_SLASH && n1 == CH_SLASH) begin
				skip = 2'd1;
				mode = MODE_LINE;
				return CH_SP;
			end
			if (c == CH_SLASH && n1 == CH_STAR) begin
				skip = 2'd1;
				mode = MODE_BLOCK;
				return CH_SP;
			end
			if (c == CH_HASH) begin
				mode = MODE_LINE;
				return CH_SP;
			end
			return c;
		endfunction

		// Note one accepted source byte and queue the bytes it releases
		function void take_source_byte(logic [7:0] b, logic last);
			logic [7:0] seq [5];
			text_beat_t beat;
			int n;
			for (int k = 0; k < 5; k++)
				seq[k] = CH_NUL;
			n = fill;
			seq[0] = window[0];
			seq[1] = window[1];
			seq[n] = b;
			n = n + 1;
			if (!last) begin
				if (n < 3) begin
					window[n - 1] = b;
					fill = n;
					return;
				end
				beat.data = blank_byte(seq[0], seq[1], seq[2]);
				beat.last = 1'b0;
				blanked_due.push_back(beat);
				window[0] = seq[1];
				window[1] = seq[2];
				fill = 2;
				return;
			end
			// Flush the window; lookahead past the end reads as zero
			for (int k = 0; k < n; k++) begin
				beat.data = blank_byte(seq[k], seq[k + 1], seq[k + 2]);
				beat.last = (k + 1 == n);
				blanked_due.push_back(beat);
			end
			clear_lexer();
		endfunction

		// Compare one output transaction with the oldest queued byte
		function void check_blanked_byte(logic [7:0] b, logic last);
			text_beat_t beat;
			if (blanked_due.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected output byte %02h last %0b", b, last);
				return;
			end
			beat = blanked_due.pop_front();
			if (beat.data !== b || beat.last !== last) begin
				faults++;
				if (faults <= 10)
					$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
						beat.data, beat.last, b, last);
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT = 4000;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	blanked_text_board board = new();
	bit steady = 1'b0;
	int idle_cycles = 0;
	int sent_random = 0;

	comment_and_docstring_blanker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none during steady stretches
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Drive one source byte and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	// Hold the sender off until every queued byte has come out
	task automatic drain_output();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	// Build a text from lexical fragments with random bytes mixed in
	task automatic send_random_text(input int len);
		logic [7:0] txt [$];
		while (txt.size() < len) begin
			case ($urandom_range(0, 13))
				0, 1, 2: txt.push_back(8'($urandom_range(0, 255)));
				3: txt.push_back(8'h61 + 8'($urandom_range(0, 25)));
				4: txt.push_back(CH_NL);
				5: txt.push_back(CH_SQ);
				6: txt.push_back(CH_DQ);
				7: txt = {txt, CH_SLASH, CH_SLASH};
				8: txt = {txt, CH_SLASH, CH_STAR};
				9: txt = {txt, CH_STAR, CH_SLASH};
				10: txt = {txt, CH_SQ, CH_SQ, CH_SQ};
				11: txt = {txt, CH_DQ, CH_DQ, CH_DQ};
				12: txt.push_back(CH_HASH);
				default: txt.push_back(CH_BSL);
			endcase
		end
		foreach (txt[i])
			send_byte(txt[i], i == txt.size() - 1);
		sent_random += txt.size();
	endtask

	// Receiver: alternate ready bursts with stalls
	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Monitor both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.take_source_byte(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				board.check_blanked_byte(m_axis_tdata, m_axis_tlast);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= CH_NUL;
		s_axis_tlast <= 1'b0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one- and two-byte texts, each comment kind, escapes, triples
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_HASH, 1'b1);
		send_string("//\n#");
		send_string("'\\''");
		send_string("\"\\\"");
		send_string("/*\n*/");
		send_string("'''a'''");
		send_string("\"\"\"x");
		drain_output();

		// Random texts, mostly short, with steady stretches and drain pauses;
		// together with the directed texts about 250 bytes in all
		while (sent_random < 220) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0)
				send_random_text($urandom_range(1, 3));
			else
				send_random_text($urandom_range(4, 24));
			if ($urandom_range(0, 5) == 0)
				drain_output();
		end
		steady = 1'b0;
		drain_output();
		repeat (8) @(posedge clk);

		if (board.faults == 0 && board.outstanding() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== comment_and_docstring_blanker.f =====
sv/csb_pkg.sv
sv/csb_lex.sv
sv/comment_and_docstring_blanker.sv
dv/comment_and_docstring_blanker_tb.sv
